// ----- rtl/gfm_pkg.sv -----
// Shared types and constants for the GF(2^128) multiplier pipeline.
// No dependencies; every other file of the block but gfm_if imports this package.
`default_nettype none

package gfm_pkg;

   // One 64-bit half of a field element
   typedef logic [63:0] word_type;

   // Carry-less product of two 32-bit quarters
   typedef logic [62:0] part_type;

   // Reduction shifts for x^128 + x^7 + x^2 + x + 1
   localparam int RED_SHIFT_A = 1;
   localparam int RED_SHIFT_B = 2;
   localparam int RED_SHIFT_C = 7;

   // Bits of the top word pushed past degree 255 by those shifts
   localparam int FOLD_SHIFT_A = 64 - RED_SHIFT_A;
   localparam int FOLD_SHIFT_B = 64 - RED_SHIFT_B;
   localparam int FOLD_SHIFT_C = 64 - RED_SHIFT_C;

   // Operands held after the input stage, with the Karatsuba middle terms
   typedef struct packed {
      word_type a_lo;
      word_type a_hi;
      word_type a_mid;
      word_type b_lo;
      word_type b_hi;
      word_type b_mid;
   } op_set_type;

   // Four quarter products that make up one 64x64 carry-less multiply
   typedef struct packed {
      part_type ll;
      part_type lh;
      part_type hl;
      part_type hh;
   } partial_type;

   // Quarter products of all three Karatsuba multiplies
   typedef struct packed {
      partial_type lo;
      partial_type hi;
      partial_type mid;
   } partial_set_type;

   // Unreduced 256-bit product as four 64-bit words
   typedef struct packed {
      word_type w3;
      word_type w2;
      word_type w1;
      word_type w0;
   } wide_type;

endpackage

`default_nettype wire

// ----- rtl/gfm_if.sv -----
// Handshake channels of the GF(2^128) multiplier: operand and product items.
// Uses no package; valid/ready with a source and a sink modport.
`default_nettype none

interface gfm_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] a_lo;
   logic [63:0] a_hi;
   logic [63:0] b_lo;
   logic [63:0] b_hi;

   modport source (output valid, output a_lo, output a_hi, output b_lo, output b_hi,
                   input ready);
   modport sink   (input valid, input a_lo, input a_hi, input b_lo, input b_hi,
                   output ready);
endinterface

interface gfm_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] prod_lo;
   logic [63:0] prod_hi;

   modport source (output valid, output prod_lo, output prod_hi, input ready);
   modport sink   (input valid, input prod_lo, input prod_hi, output ready);
endinterface

`default_nettype wire

// ----- rtl/gfm_partial.sv -----
// Pipeline stage two: twelve 32x32 carry-less quarter products.
// Depends on gfm_pkg for the operand and partial product types.
`default_nettype none

module gfm_partial
   import gfm_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            in_valid,
   output      logic            in_ready,
   input  wire op_set_type      in_ops,
   output      logic            out_valid,
   input  wire logic            out_ready,
   output      partial_set_type out_parts
);

   logic            valid_ff;
   partial_set_type parts_ff;
   partial_set_type parts_in;

   // Form each product bit as the parity of its independent terms
   function automatic part_type clmul32(input logic [31:0] x, input logic [31:0] y);
      part_type    r;
      logic [31:0] t;
      for (int k = 0; k < 63; k++) begin
         for (int i = 0; i < 32; i++) begin
            if ((k - i >= 0) && (k - i <= 31)) begin
               t[i] = x[i] & y[5'(k - i)];
            end else begin
               t[i] = 1'b0;
            end
         end
         r[k] = ^t;
      end
      return r;
   endfunction

   // Split a 64x64 multiply into its four quarter products
   function automatic partial_type split(input word_type x, input word_type y);
      partial_type p;
      p.ll = clmul32(x[31:0],  y[31:0]);
      p.lh = clmul32(x[31:0],  y[63:32]);
      p.hl = clmul32(x[63:32], y[31:0]);
      p.hh = clmul32(x[63:32], y[63:32]);
      return p;
   endfunction

   // Compute the quarter products of all three multiplies
   always_comb begin
      parts_in.lo  = split(in_ops.a_lo,  in_ops.b_lo);
      parts_in.hi  = split(in_ops.a_hi,  in_ops.b_hi);
      parts_in.mid = split(in_ops.a_mid, in_ops.b_mid);
   end

   // Advance when empty or when the next stage takes the item
   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         parts_ff <= parts_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_parts = parts_ff;

endmodule

`default_nettype wire

// ----- rtl/gfm_karatsuba.sv -----
// Pipeline stage three: join quarter products and combine Karatsuba terms.
// Depends on gfm_pkg for the partial product and wide product types.
`default_nettype none

module gfm_karatsuba
   import gfm_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            in_valid,
   output      logic            in_ready,
   input  wire partial_set_type in_parts,
   output      logic            out_valid,
   input  wire logic            out_ready,
   output      wide_type        out_wide
);

   logic         valid_ff;
   wide_type     wide_ff;
   wide_type     wide_in;
   logic [127:0] prod_hh;
   logic [127:0] prod_ll;
   logic [127:0] prod_mm;

   // Place the quarter products at their weights in a 128-bit product
   function automatic logic [127:0] join_parts(input partial_type p);
      return {65'b0, p.ll} ^ {33'b0, p.lh ^ p.hl, 32'b0} ^ {1'b0, p.hh, 64'b0};
   endfunction

   // Combine low, high and middle products into the 256-bit result
   always_comb begin
      prod_hh    = join_parts(in_parts.hi);
      prod_ll    = join_parts(in_parts.lo);
      prod_mm    = join_parts(in_parts.mid);
      wide_in.w3 = prod_hh[127:64];
      wide_in.w2 = prod_hh[63:0] ^ prod_hh[127:64] ^ prod_ll[127:64] ^ prod_mm[127:64];
      wide_in.w1 = prod_ll[127:64] ^ prod_hh[63:0] ^ prod_ll[63:0] ^ prod_mm[63:0];
      wide_in.w0 = prod_ll[63:0];
   end

   // Advance when empty or when the next stage takes the item
   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         wide_ff <= wide_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_wide  = wide_ff;

endmodule

`default_nettype wire

// ----- rtl/gfm_reduce.sv -----
// Pipeline stage four: reduce the 256-bit product modulo x^128+x^7+x^2+x+1.
// Depends on gfm_pkg for the wide product type and the shift constants.
`default_nettype none

module gfm_reduce
   import gfm_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     in_valid,
   output      logic     in_ready,
   input  wire wide_type in_wide,
   output      logic     out_valid,
   input  wire logic     out_ready,
   output      word_type prod_lo,
   output      word_type prod_hi
);

   logic     valid_ff;
   word_type prod_lo_ff;
   word_type prod_hi_ff;
   word_type prod_lo_in;
   word_type prod_hi_in;
   word_type fold;

   // Fold the overflow of the top word, then shift-and-add the upper half
   always_comb begin
      fold = in_wide.w2 ^ (in_wide.w3 >> FOLD_SHIFT_A) ^ (in_wide.w3 >> FOLD_SHIFT_B)
           ^ (in_wide.w3 >> FOLD_SHIFT_C);
      prod_lo_in = in_wide.w0 ^ fold ^ (fold << RED_SHIFT_A) ^ (fold << RED_SHIFT_B)
                 ^ (fold << RED_SHIFT_C);
      prod_hi_in = in_wide.w1 ^ in_wide.w3
                 ^ ((in_wide.w3 << RED_SHIFT_A) | (fold >> FOLD_SHIFT_A))
                 ^ ((in_wide.w3 << RED_SHIFT_B) | (fold >> FOLD_SHIFT_B))
                 ^ ((in_wide.w3 << RED_SHIFT_C) | (fold >> FOLD_SHIFT_C));
   end

   // Hold the result until the consumer takes it
   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         prod_lo_ff <= prod_lo_in;
         prod_hi_ff <= prod_hi_in;
      end
   end

   assign out_valid = valid_ff;
   assign prod_lo   = prod_lo_ff;
   assign prod_hi   = prod_hi_ff;

`ifndef SYNTHESIS
   // An item taken in is on the output in the next cycle
   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      (!reset && in_valid && in_ready) |=> out_valid)
      else $error("reduce stage lost an item");

   // A stalled result keeps its value
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (out_valid && !out_ready) |=> (out_valid && $stable(prod_lo) && $stable(prod_hi)))
      else $error("reduce stage changed a stalled result");

   // With an empty upper half the reduction passes the lower half through
   a_no_upper: assert property (@(posedge clock) disable iff (reset)
      (!reset && in_valid && in_ready && in_wide.w3 == '0 && in_wide.w2 == '0) |=>
      (prod_lo == $past(in_wide.w0) && prod_hi == $past(in_wide.w1)))
      else $error("reduction altered a product below degree 128");
`endif

endmodule

`default_nettype wire

// ----- rtl/gf128_multiply.sv -----
// Top level of the GF(2^128) multiplier: input stage and the pipeline chain.
// Depends on gfm_pkg, gfm_if, gfm_partial, gfm_karatsuba and gfm_reduce.
`default_nettype none

// Multiplies two elements of GF(2^128), polynomial basis, modulus
// x^128 + x^7 + x^2 + x + 1, bit 0 of a_lo being degree 0. The block is a
// four-stage pipeline (operand register, 32x32 carry-less quarter products,
// Karatsuba combine, reduction) and takes one item per clock cycle while the
// output is not stalled; each product passes the stage registers in that
// order and is held on rsp_ch by the reduction register until it is taken. Every
// stage holds its item while the stage after it is full and stalled, so
// back-pressure on rsp_ch ripples up to req_ch without loss.
// The block has no state beyond the pipeline; reset empties it.
module gf128_multiply
   import gfm_pkg::*;
(
   input wire logic  clock,
   input wire logic  reset,
   gfm_req_if.sink   req_ch,
   gfm_rsp_if.source rsp_ch
);

   logic            s1_valid_ff;
   op_set_type      s1_ops_ff;
   op_set_type      s1_ops_in;
   logic            s1_ready;
   logic            s2_valid;
   logic            s2_ready;
   partial_set_type s2_parts;
   logic            s3_valid;
   logic            s3_ready;
   wide_type        s3_wide;
   logic            s4_ready;

   // Take the operands and form the Karatsuba middle terms
   always_comb begin
      s1_ops_in.a_lo  = req_ch.a_lo;
      s1_ops_in.a_hi  = req_ch.a_hi;
      s1_ops_in.a_mid = req_ch.a_lo ^ req_ch.a_hi;
      s1_ops_in.b_lo  = req_ch.b_lo;
      s1_ops_in.b_hi  = req_ch.b_hi;
      s1_ops_in.b_mid = req_ch.b_lo ^ req_ch.b_hi;
   end

   assign s1_ready     = !s1_valid_ff || s2_ready;
   assign req_ch.ready = s1_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && req_ch.valid) begin
         s1_ops_ff <= s1_ops_in;
      end
   end

   // Quarter products
   gfm_partial u_partial (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid_ff),
      .in_ready  (s2_ready),
      .in_ops    (s1_ops_ff),
      .out_valid (s2_valid),
      .out_ready (s3_ready),
      .out_parts (s2_parts)
   );

   // Karatsuba combine
   gfm_karatsuba u_karatsuba (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid),
      .in_ready  (s3_ready),
      .in_parts  (s2_parts),
      .out_valid (s3_valid),
      .out_ready (s4_ready),
      .out_wide  (s3_wide)
   );

   // Modular reduction and output register
   gfm_reduce u_reduce (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_valid),
      .in_ready  (s4_ready),
      .in_wide   (s3_wide),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .prod_lo   (rsp_ch.prod_lo),
      .prod_hi   (rsp_ch.prod_hi)
   );

`ifndef SYNTHESIS
   // A consumer that takes the result leaves every stage free to advance
   a_chain_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.ready |-> (req_ch.ready && s2_ready && s3_ready && s4_ready))
      else $error("pipeline blocked while the output drains");

   // The input stage only refuses an item while every stage, itself included, holds one
   a_input_full: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> (s1_valid_ff && s2_valid && s3_valid && rsp_ch.valid))
      else $error("input refused with a free stage in the pipeline");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/gf128_multiply_tb.sv -----
// Self-checking bench for gf128_multiply: directed and random operand pairs,
// products checked against a shift-and-reduce model of GF(2^128) multiplication.
// Depends on gfm_pkg, gfm_if and the gf128_multiply RTL.
`timescale 1ns / 100ps

module gf128_multiply_tb;
   import gfm_pkg::*;

   // x^7 + x^2 + x + 1: what x^128 folds back to
   localparam logic [127:0] MODULUS_TAIL = 128'h87;

   localparam int RANDOM_ITEMS = 1750;
   localparam int CALM_FROM    = 400;    // no idling on either side from here ...
   localparam int CALM_TO      = 700;    // ... to here
   localparam int HOLD_AT      = 1100;   // product side holds off once this many are taken
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 20;
   localparam int CYCLE_LIMIT  = 200000;

   typedef struct packed {
      word_type hi;
      word_type lo;
   } elem_type;

   // Holds the expected products in order and checks each one taken from the block
   class gf_product_board;
      elem_type pending_products[$];
      int       fault_count;

      function new();
         fault_count = 0;
      endfunction

      // Horner evaluation over the bits of b, reducing after every doubling
      static function elem_type field_multiply(elem_type a, elem_type b);
         logic [127:0] acc;
         acc = '0;
         for (int i = 127; i >= 0; i--) begin
            acc = {acc[126:0], 1'b0} ^ (acc[127] ? MODULUS_TAIL : 128'd0);
            if (b[i]) acc ^= a;
         end
         return acc;
      endfunction

      function void note_operands(word_type a_lo, a_hi, b_lo, b_hi);
         pending_products.push_back(field_multiply({a_hi, a_lo}, {b_hi, b_lo}));
      endfunction

      function void check_product(word_type prod_lo, prod_hi);
         elem_type want;
         if (pending_products.size() == 0) begin
            $display("%0t: product %h_%h taken with none expected", $time, prod_hi, prod_lo);
            fault_count++;
            return;
         end
         want = pending_products.pop_front();
         if (prod_lo !== want.lo) begin
            $display("%0t: prod_lo expected %h actual %h", $time, want.lo, prod_lo);
            fault_count++;
         end
         if (prod_hi !== want.hi) begin
            $display("%0t: prod_hi expected %h actual %h", $time, want.hi, prod_hi);
            fault_count++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   gfm_req_if req_ch();
   gfm_rsp_if rsp_ch();

   gf128_multiply dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   gf_product_board product_board;
   int cycle_count    = 0;
   int operands_taken = 0;
   int items_offered  = 0;

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Give up well past the slowest correct run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Note every operand item the block accepts
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready) begin
         product_board.note_operands(req_ch.a_lo, req_ch.a_hi, req_ch.b_lo, req_ch.b_hi);
         operands_taken <= operands_taken + 1;
      end
   end

   // Check every product item the block hands over
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         product_board.check_product(rsp_ch.prod_lo, rsp_ch.prod_hi);
   end

   // Product side: random stalls, a calm stretch and one long hold-off
   initial begin : product_drain
      int  hold_left;
      bit  hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!hold_done && operands_taken >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (operands_taken >= CALM_FROM && operands_taken < CALM_TO) begin
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= 25);
         end
      end
   end

   // Offer one operand pair, idling first now and then, and wait for it to be taken
   task automatic offer_operands(input word_type a_lo, a_hi, b_lo, b_hi);
      bit steady;
      steady = (items_offered >= CALM_FROM && items_offered < CALM_TO) ||
               (items_offered >= HOLD_AT - 20 && items_offered < HOLD_AT + 150);
      if (!steady && $urandom_range(0, 99) < 25) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 2)) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.a_lo  <= a_lo;
      req_ch.a_hi  <= a_hi;
      req_ch.b_lo  <= b_lo;
      req_ch.b_hi  <= b_hi;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      items_offered++;
   endtask

   // One operand half: zero, all ones, one bit, a few bits or fully random
   function automatic word_type pick_half();
      word_type w;
      case ($urandom_range(0, 9))
         0: w = '0;
         1: w = '1;
         2: w = 64'd1 << $urandom_range(0, 63);
         3: w = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
         default: w = {$urandom, $urandom};
      endcase
      return w;
   endfunction

   function automatic word_type any_half();
      return {$urandom, $urandom};
   endfunction

   initial begin
      product_board = new();
      reset         <= 1'b1;
      req_ch.valid  <= 1'b0;
      req_ch.a_lo   <= '0;
      req_ch.a_hi   <= '0;
      req_ch.b_lo   <= '0;
      req_ch.b_hi   <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: zero and one, field extremes, top-degree terms that need folding
      offer_operands('0, '0, '0, '0);
      offer_operands('1, '1, '1, '1);
      offer_operands(64'd1, '0, '1, '1);
      offer_operands('1, '1, '0, '0);
      offer_operands(64'd1, '0, 64'd1, '0);
      offer_operands('0, 64'h8000_0000_0000_0000, '0, 64'h8000_0000_0000_0000);
      offer_operands('0, 64'h8000_0000_0000_0000, 64'd2, '0);
      offer_operands('0, 64'd1, '0, 64'd1);
      offer_operands(64'h8000_0000_0000_0000, '0, '0, 64'd1);
      offer_operands('0, 64'h8000_0000_0000_0000, '1, '1);
      offer_operands('0, 64'hFE00_0000_0000_0000, '0, 64'hFE00_0000_0000_0000);
      offer_operands(64'h5555_5555_5555_5555, 64'h5555_5555_5555_5555,
                     64'hAAAA_AAAA_AAAA_AAAA, 64'hAAAA_AAAA_AAAA_AAAA);
      offer_operands(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
                     64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
      offer_operands(any_half(), any_half(), '0, '0);
      offer_operands(any_half(), any_half(), 64'd1, '0);
      offer_operands('1, 64'h8000_0000_0000_0001, any_half(), '1);
      offer_operands('1, '0, '1, '0);
      offer_operands('0, '1, '0, '1);
      repeat (4) offer_operands(any_half(), any_half(), any_half(), any_half());

      // Random: mostly dense operands, with zero, full, single-bit and sparse halves mixed in
      repeat (RANDOM_ITEMS) offer_operands(pick_half(), pick_half(), pick_half(), pick_half());
      req_ch.valid <= 1'b0;

      // Drain the pipeline, then let it settle
      while (product_board.pending_products.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (product_board.fault_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/gfm_pkg.sv
rtl/gfm_if.sv
rtl/gfm_partial.sv
rtl/gfm_karatsuba.sv
rtl/gfm_reduce.sv
rtl/gf128_multiply.sv
tb/sv/gf128_multiply_tb.sv
